// File: src/txrb_pkg.sv
// Shared types and constants for the transmit ring buffer DMA chunker.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package txrb_pkg;

    // Default depth of the byte ring.
    localparam int BUFFER_DEPTH_DEF = 1024;

    // Request kinds carried in the low bits of the slave-side tuser.
    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_COMPLETE = 2'd1;
    localparam logic [1:0] REQ_FETCH    = 2'd2;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    // Field widths of the beats.
    localparam int REQ_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int MLEN_W   = 16;
    localparam int OFS_W    = 10;
    localparam int FREE_W   = 10;
    localparam int CSTART_W = 10;
    localparam int CLEN_W   = 11;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 56;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic step;      // an input beat is taken this cycle
        logic write;     // message byte
        logic complete;  // transfer complete event
        logic fetch;     // chunk byte read
    } t_cmd;

endpackage

// File: src/tx_ring_buffer_dma_chunker_top.sv
// Top level of the transmit ring buffer DMA chunker.
// Depends on txrb_pkg, txrb_ctrl and txrb_dpath.
//
//  channel | dir | tdata (lowest bit up)                         | tuser / tlast
//  --------+-----+-----------------------------------------------+--------------------------
//  s_axis  | in  | data_byte, msg_len, fetch_offset, zero pad    | req_type, first / last
//  m_axis  | out | accepted_len, free_bytes, start_transfer,     | none
//          |     | chunk_start, chunk_length, fetched_byte       |
//
// A beat taken shows its result in the cycle after, and a new beat is taken in
// the same cycle the result drains, so the block sustains one beat per cycle
// while m_axis is ready. The single result register and the store's registered
// read port set that rate.
// Reset is synchronous, active low, and clears the ring indices and the result
// slot; the byte store needs no clearing pass. A stalled m_axis holds the
// result and backs pressure onto s_axis.
`timescale 1ns / 1ps

module tx_ring_buffer_dma_chunker_top #(
    parameter int BUFFER_DEPTH = txrb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // s_axis: tdata = data_byte[7:0], msg_len[23:8], fetch_offset[33:24], zero[39:34]
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [txrb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // s_axis: tuser = req_type[1:0], first_of_message[2]
    input  logic [txrb_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    input  logic                                 s_axis_tlast,  // last_of_message
    // m_axis: tdata = accepted_len[15:0], free_bytes[25:16], start_transfer[26],
    //         chunk_start[36:27], chunk_length[47:37], fetched_byte[55:48]
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [txrb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    txrb_pkg::t_cmd cmd;

    logic [txrb_pkg::MLEN_W-1:0]   acc_len;
    logic [txrb_pkg::FREE_W-1:0]   free_bytes;
    logic                          start_xfer;
    logic [txrb_pkg::CSTART_W-1:0] chunk_start;
    logic [txrb_pkg::CLEN_W-1:0]   chunk_len;
    logic [txrb_pkg::BYTE_W-1:0]   fetched;

    // Handshake and request decode
    txrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_req_type  (s_axis_tuser[1:0]),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // Ring bookkeeping, chunk scheduling and the byte store
    txrb_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_data_byte        (s_axis_tdata[7:0]),
        .i_msg_len          (s_axis_tdata[23:8]),
        .i_first_of_message (s_axis_tuser[2]),
        .i_last_of_message  (s_axis_tlast),
        .i_fetch_offset     (s_axis_tdata[33:24]),
        .o_accepted_len     (acc_len),
        .o_free_bytes       (free_bytes),
        .o_start_transfer   (start_xfer),
        .o_chunk_start      (chunk_start),
        .o_chunk_length     (chunk_len),
        .o_fetched_byte     (fetched)
    );

    // Pack the result beat, first field in the lowest bits.
    assign m_axis_tdata = {fetched, chunk_len, chunk_start, start_xfer, free_bytes, acc_len};

endmodule

// File: src/txrb_ctrl.sv
// Handshake controller of the transmit ring buffer: one result register slot.
// Depends on txrb_pkg.
`timescale 1ns / 1ps

module txrb_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [txrb_pkg::REQ_W-1:0] i_req_type,
    input  logic                   i_out_ready,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output txrb_pkg::t_cmd         o_cmd
);

    localparam logic S_EMPTY = 1'b0;
    localparam logic S_FULL  = 1'b1;

    logic r_state;
    logic n_state;
    logic step;

    // A new beat may enter when the result slot is empty or drains now.
    assign o_in_ready  = (r_state == S_EMPTY) || i_out_ready;
    assign o_out_valid = (r_state == S_FULL);
    assign step        = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        if (step) begin
            n_state = S_FULL;
        end else if (i_out_ready) begin
            n_state = S_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.step     = step;
        unique case (i_req_type)
            txrb_pkg::REQ_WRITE:    o_cmd.write    = step;
            txrb_pkg::REQ_COMPLETE: o_cmd.complete = step;
            txrb_pkg::REQ_FETCH:    o_cmd.fetch    = step;
            default:                o_cmd.write    = 1'b0;
        endcase
    end

endmodule

// File: src/txrb_dpath.sv
// Datapath of the transmit ring buffer: ring indices, chunk scheduler, byte store,
// result registers. Depends on txrb_pkg.
`timescale 1ns / 1ps

module txrb_dpath #(
    parameter int BUFFER_DEPTH = txrb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  txrb_pkg::t_cmd                    i_cmd,
    input  logic [txrb_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic [txrb_pkg::MLEN_W-1:0]       i_msg_len,
    input  logic                              i_first_of_message,
    input  logic                              i_last_of_message,
    input  logic [txrb_pkg::OFS_W-1:0]        i_fetch_offset,
    output logic [txrb_pkg::MLEN_W-1:0]       o_accepted_len,
    output logic [txrb_pkg::FREE_W-1:0]       o_free_bytes,
    output logic                              o_start_transfer,
    output logic [txrb_pkg::CSTART_W-1:0]     o_chunk_start,
    output logic [txrb_pkg::CLEN_W-1:0]       o_chunk_length,
    output logic [txrb_pkg::BYTE_W-1:0]       o_fetched_byte
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = AW + 1;
    localparam int SW = ((AW > txrb_pkg::OFS_W) ? AW : txrb_pkg::OFS_W) + 1;
    localparam int LW = txrb_pkg::MLEN_W + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(BUFFER_DEPTH);

    function automatic logic [AW-1:0] free_of(input logic [AW-1:0] comm,
                                              input logic [AW-1:0] rd);
        logic [AW-1:0] res;
        if (comm >= rd) begin
            res = LAST_IDX - (comm - rd);
        end else begin
            res = rd - comm - AW'(1);
        end
        return res;
    endfunction

    function automatic logic [CW-1:0] chunk_of(input logic [AW-1:0] rd,
                                               input logic [AW-1:0] comm);
        logic [CW-1:0] res;
        if (rd < comm) begin
            res = CW'(comm - rd);
        end else begin
            res = DEPTH_C - CW'(rd);
        end
        return res;
    endfunction

    // Ring state
    logic [AW-1:0] r_comm, n_comm;
    logic [AW-1:0] r_stg,  n_stg;
    logic [AW-1:0] r_rd,   n_rd;
    logic [CW-1:0] r_len,  n_len;
    logic          r_act,  n_act;
    logic          r_drop, n_drop;

    // Byte store and its registered read
    logic [txrb_pkg::BYTE_W-1:0] r_mem [BUFFER_DEPTH];
    logic [txrb_pkg::BYTE_W-1:0] r_rd_data;

    // Result registers
    logic [txrb_pkg::MLEN_W-1:0]   r_acc;
    logic [txrb_pkg::FREE_W-1:0]   r_free;
    logic                          r_start;
    logic [txrb_pkg::CSTART_W-1:0] r_cstart;
    logic [txrb_pkg::CLEN_W-1:0]   r_clen;
    logic                          r_hit;

    logic [txrb_pkg::MLEN_W-1:0] v_acc;
    logic                        v_start;
    logic                        v_wr_en;
    logic [AW-1:0]               v_wr_addr;
    logic [AW-1:0]               v_next;
    logic [CW-1:0]               v_sum;
    logic                        v_hit;
    logic [AW-1:0]               v_rd_addr;
    logic [AW-1:0]               v_free_now;
    logic [AW-1:0]               v_free_after;

    assign v_free_now = free_of(r_comm, r_rd);
    assign v_hit = r_act && (SW'(i_fetch_offset) < SW'(r_len));
    // In range the sum stays below the depth, so no wrap is needed.
    assign v_rd_addr = AW'(SW'(r_rd) + SW'(i_fetch_offset));

    always_comb begin
        n_comm    = r_comm;
        n_stg     = r_stg;
        n_rd      = r_rd;
        n_len     = r_len;
        n_act     = r_act;
        n_drop    = r_drop;
        v_acc     = '0;
        v_start   = 1'b0;
        v_wr_en   = 1'b0;
        v_wr_addr = r_stg;
        v_next    = '0;
        v_sum     = '0;
        if (i_cmd.write) begin
            if (i_first_of_message) begin
                n_stg  = r_comm;
                n_drop = (i_msg_len == '0) || (LW'(i_msg_len) > LW'(v_free_now));
            end
            if (!n_drop) begin
                v_next = (n_stg == LAST_IDX) ? '0 : n_stg + AW'(1);
                if (v_next == r_rd) begin
                    n_drop = 1'b1;
                end else begin
                    v_wr_en   = 1'b1;
                    v_wr_addr = n_stg;
                    n_stg     = v_next;
                end
            end
            if (i_last_of_message && !n_drop) begin
                n_comm = n_stg;
                v_acc  = i_msg_len;
                if (!r_act && (n_stg != r_rd)) begin
                    n_len   = chunk_of(r_rd, n_stg);
                    n_act   = 1'b1;
                    v_start = 1'b1;
                end
            end
        end else if (i_cmd.complete) begin
            if (r_act) begin
                v_sum = CW'(r_rd) + r_len;
                n_rd  = (v_sum == DEPTH_C) ? '0 : AW'(v_sum);
                n_act = 1'b0;
                n_len = '0;
                if (r_comm != n_rd) begin
                    n_len   = chunk_of(n_rd, r_comm);
                    n_act   = 1'b1;
                    v_start = 1'b1;
                end
            end
        end
    end

    assign v_free_after = free_of(n_comm, n_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comm <= '0;
            r_stg  <= '0;
            r_rd   <= '0;
            r_len  <= '0;
            r_act  <= 1'b0;
            r_drop <= 1'b0;
        end else begin
            r_comm <= n_comm;
            r_stg  <= n_stg;
            r_rd   <= n_rd;
            r_len  <= n_len;
            r_act  <= n_act;
            r_drop <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_wr_en) begin
            r_mem[v_wr_addr] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch && v_hit) begin
            r_rd_data <= r_mem[v_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_acc    <= v_acc;
            r_free   <= txrb_pkg::FREE_W'(v_free_after);
            r_start  <= v_start;
            r_cstart <= txrb_pkg::CSTART_W'(n_rd);
            r_clen   <= txrb_pkg::CLEN_W'(n_len);
            r_hit    <= i_cmd.fetch && v_hit;
        end
    end

    assign o_accepted_len   = r_acc;
    assign o_free_bytes     = r_free;
    assign o_start_transfer = r_start;
    assign o_chunk_start    = r_cstart;
    assign o_chunk_length   = r_clen;
    assign o_fetched_byte   = r_hit ? r_rd_data : '0;

endmodule

// File: src/txrb_chk.sv
// Port-level checker for the transmit ring buffer, bound to the top level.
// Depends on txrb_pkg and tx_ring_buffer_dma_chunker_top.
`timescale 1ns / 1ps

module txrb_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [txrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // Hold a stalled result beat unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // Every taken beat shows its result at the next edge.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("result beat missing after input beat");

    // A scheduled chunk is never empty.
    a_start_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tdata[47:37] != 11'd0)
        else $error("transfer started with empty chunk");

    // A fetched byte only comes from an active chunk.
    a_fetch_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[55:48] != 8'd0 |-> m_axis_tdata[47:37] != 11'd0)
        else $error("fetched byte without active chunk");

endmodule

bind tx_ring_buffer_dma_chunker_top txrb_chk u_txrb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
